@@ hdl/base64_stream_encoder_defines.svh @@
// Assertion macros shared by the base64 stream encoder RTL.
// Included by the modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define B64E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// cond must never be true outside reset
`define B64E_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define B64E_ASSERT(lbl, prop, msg)

`define B64E_NEVER(lbl, cond, msg)

`endif

`endif

@@ hdl/b64e_pkg.sv @@
// Types, constants and the sextet-to-ASCII mapping of the base64 stream encoder.
// No dependencies; used by every module of the block.
`default_nettype none

package b64e_pkg;

  localparam int unsigned GroupFifoDepth = 2;

  localparam logic [6:0] PadChar = 7'h3D;

  // number of message bytes in a group
  typedef enum logic [1:0] {
    LEN_ONE   = 2'd1,
    LEN_TWO   = 2'd2,
    LEN_THREE = 2'd3
  } group_len_e;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    group_len_e len;
    logic       last;
  } group_t;

  // standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] ch;
    if (v < 6'd26) begin
      ch = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      ch = 7'h47 + {1'b0, v};
    end else if (v < 6'd62) begin
      ch = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      ch = 7'h2B;
    end else begin
      ch = 7'h2F;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ hdl/b64e_front.sv @@
// Front end: accepts message bytes, gathers them into groups of up to three.
// Uses b64e_pkg; pushes complete or final groups into the group queue.
`default_nettype none

`include "base64_stream_encoder_defines.svh"

module b64e_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             end_of_message_i,
  output logic                  full_o,
  input  wire logic             grp_full_i,
  output logic                  grp_push_o,
  output b64e_pkg::group_t      grp_o
);

  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] pend_q;
  logic        accept;
  logic        complete;

  assign full_o   = grp_full_i;
  assign accept   = push_i && !full_o;
  assign complete = (cnt_q == 2'd2) || end_of_message_i;

  assign grp_push_o = accept && complete;

  always_comb begin
    grp_o.b0   = (cnt_q == 2'd0) ? data_byte_i : pend_q[15:8];
    grp_o.b1   = (cnt_q == 2'd1) ? data_byte_i :
                 (cnt_q == 2'd2) ? pend_q[7:0] : 8'h00;
    grp_o.b2   = (cnt_q == 2'd2) ? data_byte_i : 8'h00;
    grp_o.len  = b64e_pkg::group_len_e'(cnt_q + 2'd1);
    grp_o.last = end_of_message_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = complete ? 2'd0 : cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // pending bytes are only read under a nonzero count
  always_ff @(posedge clk_i) begin
    if (accept && !complete) begin
      if (cnt_q == 2'd0) begin
        pend_q[15:8] <= data_byte_i;
      end else begin
        pend_q[7:0] <= data_byte_i;
      end
    end
  end

  `B64E_NEVER(a_front_cnt_range, cnt_q == 2'd3, "pending count out of range")
  `B64E_NEVER(a_front_push_full, grp_push_o && grp_full_i, "group pushed into full queue")

endmodule

`default_nettype wire

@@ hdl/b64e_fifo.sv @@
// Short group queue between the front end and the character back end.
// Uses b64e_pkg for the group record; depth is a power of two, at least 2.
`default_nettype none

`include "base64_stream_encoder_defines.svh"

module b64e_fifo #(
  parameter int unsigned Depth = b64e_pkg::GroupFifoDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire b64e_pkg::group_t  wdata_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output b64e_pkg::group_t       rdata_o
);

  localparam int unsigned AddrW = $clog2(Depth);

  b64e_pkg::group_t mem_q [Depth];

  logic [AddrW:0] wr_ptr_q, rd_ptr_q;

  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign full_o  = (wr_ptr_q[AddrW] != rd_ptr_q[AddrW]) &&
                   (wr_ptr_q[AddrW-1:0] == rd_ptr_q[AddrW-1:0]);
  assign rdata_o = mem_q[rd_ptr_q[AddrW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= wr_ptr_q + {{AddrW{1'b0}}, 1'b1};
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= rd_ptr_q + {{AddrW{1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q[AddrW-1:0]] <= wdata_i;
    end
  end

  `B64E_NEVER(a_fifo_pop_empty, pop_i && empty_o, "group queue popped while empty")

endmodule

`default_nettype wire

@@ hdl/b64e_back.sv @@
// Back end: splits a group into four characters, one per cycle into a free output register.
// Uses b64e_pkg for the group record, alphabet mapping and pad character.
`default_nettype none

`include "base64_stream_encoder_defines.svh"

module b64e_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             grp_empty_i,
  input  wire b64e_pkg::group_t grp_i,
  output logic                  grp_pop_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [6:0]            out_char_o,
  output logic                  last_char_o
);

  b64e_pkg::group_t grp_q;
  logic             grp_valid_q, grp_valid_d;
  logic [1:0]       idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [6:0]       out_char_q;
  logic             out_last_q;

  logic       advance;
  logic       grp_done;
  logic [5:0] sextet;
  logic       is_pad;
  logic [6:0] char_d;

  // output register is free when empty or being drained this cycle
  assign advance   = grp_valid_q && (!out_valid_q || pop_i);
  assign grp_done  = advance && (idx_q == 2'd3);
  assign grp_pop_o = !grp_empty_i && (!grp_valid_q || grp_done);

  always_comb begin
    unique case (idx_q)
      2'd0: sextet = grp_q.b0[7:2];
      2'd1: sextet = {grp_q.b0[1:0], grp_q.b1[7:4]};
      2'd2: sextet = {grp_q.b1[3:0], grp_q.b2[7:6]};
      default: sextet = grp_q.b2[5:0];
    endcase
    is_pad = ((idx_q == 2'd2) && (grp_q.len == b64e_pkg::LEN_ONE)) ||
             ((idx_q == 2'd3) && (grp_q.len != b64e_pkg::LEN_THREE));
    char_d = is_pad ? b64e_pkg::PadChar : b64e_pkg::b64_char(sextet);
  end

  always_comb begin
    grp_valid_d = grp_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !pop_i;
    if (advance) begin
      idx_d       = idx_q + 2'd1;
      out_valid_d = 1'b1;
    end
    if (grp_pop_o) begin
      grp_valid_d = 1'b1;
    end else if (grp_done) begin
      grp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      grp_valid_q <= grp_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_pop_o) begin
      grp_q <= grp_i;
    end
    if (advance) begin
      out_char_q <= char_d;
      out_last_q <= grp_q.last && (idx_q == 2'd3);
    end
  end

  assign empty_o     = !out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_last_q;

  `B64E_ASSERT(a_back_idx_in_group, (idx_q != 2'd0) |-> grp_valid_q,
               "character index set with no group held")

endmodule

`default_nettype wire

@@ hdl/base64_stream_encoder.sv @@
// Base64 (standard alphabet) stream encoder with '=' padding and end-of-message mark.
// Top level; instantiates b64e_front, b64e_fifo and b64e_back, uses b64e_pkg.
//
// Input channel: a byte and its end_of_message flag are taken on a clock edge
// with push high and full low. full is high while the group queue has no room.
// Output channel: one character per transaction; empty low means out_char_o and
// last_char_o hold the oldest character, taken on an edge with pop high.
// Every third byte, and every byte flagged end_of_message, completes a group
// that yields four characters; a short final group is padded with '='.
// last_char_o marks the fourth character of the final group.
// Path: a completed group goes into the group queue, then into the back end's group
// register; each of its characters then passes through the output register.
// Throughput: one byte per cycle on input while the queue has room; one
// character per cycle on output while the receiver pops, so the sustained
// rate is set by the character back end, at four characters per group.
// Reset clears pending bytes, the group queue and the output register.
// When the receiver stalls, the output register holds, the back end stops,
// the group queue fills and full rises; no data is lost.
`default_nettype none

module base64_stream_encoder #(
  parameter int unsigned GroupFifoDepth = b64e_pkg::GroupFifoDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_message_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [6:0]      out_char_o,
  output logic            last_char_o
);

  b64e_pkg::group_t grp_wr, grp_rd;
  logic             grp_push, grp_full, grp_pop, grp_empty;

  b64e_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .full_o           (full),
    .grp_full_i       (grp_full),
    .grp_push_o       (grp_push),
    .grp_o            (grp_wr)
  );

  b64e_fifo #(
    .Depth (GroupFifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_push),
    .wdata_i (grp_wr),
    .full_o  (grp_full),
    .pop_i   (grp_pop),
    .empty_o (grp_empty),
    .rdata_o (grp_rd)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_empty_i (grp_empty),
    .grp_i       (grp_rd),
    .grp_pop_o   (grp_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

`default_nettype wire

@@ dv/base64_stream_encoder_tb.sv @@
// Testbench for base64_stream_encoder: directed and random byte messages.
// Predicts the encoded characters in a scoreboard class and checks each popped character.
// Depends only on the base64_stream_encoder RTL.
`timescale 1ns / 1ps

typedef struct packed {
  logic [6:0] ch;
  logic       last;
} enc_char_t;

class encoded_char_board;
  localparam logic [6:0] EqualsChar = 7'h3D;

  logic [7:0] held_first;
  logic [7:0] held_second;
  int unsigned held_count;
  enc_char_t expected_chars[$];
  int unsigned mismatches;

  function new();
    held_first = '0;
    held_second = '0;
    held_count = 0;
    mismatches = 0;
  endfunction

  function automatic logic [6:0] sextet_ascii(input logic [5:0] v);
    string alphabet;
    byte   c;
    alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    c = alphabet.getc(int'(v));
    return c[6:0];
  endfunction

  function automatic void queue_char(input logic [6:0] ch, input logic last);
    enc_char_t c;
    c.ch = ch;
    c.last = last;
    expected_chars.push_back(c);
  endfunction

  // one accepted input byte; a completed or final group yields four characters
  function automatic void note_byte(input logic [7:0] data, input logic eom);
    logic [7:0] b0, b1, b2;
    int unsigned group_len;
    b0 = data;
    b1 = '0;
    b2 = '0;
    if (held_count == 1) begin
      b0 = held_first;
      b1 = data;
    end else if (held_count == 2) begin
      b0 = held_first;
      b1 = held_second;
      b2 = data;
    end
    group_len = held_count + 1;
    if (group_len < 3 && !eom) begin
      if (held_count == 0) held_first = data;
      else held_second = data;
      held_count = group_len;
      return;
    end
    queue_char(sextet_ascii(b0[7:2]), 1'b0);
    queue_char(sextet_ascii({b0[1:0], b1[7:4]}), 1'b0);
    if (group_len == 1) queue_char(EqualsChar, 1'b0);
    else queue_char(sextet_ascii({b1[3:0], b2[7:6]}), 1'b0);
    if (group_len == 3) queue_char(sextet_ascii(b2[5:0]), eom);
    else queue_char(EqualsChar, eom);
    held_count = 0;
    held_first = '0;
    held_second = '0;
  endfunction

  task report(input string msg);
    if (mismatches < 50) $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_char(input logic [6:0] ch, input logic last);
    enc_char_t exp_c;
    if (expected_chars.size() == 0) begin
      report($sformatf("unexpected character 0x%02h last=%0b", ch, last));
      return;
    end
    exp_c = expected_chars.pop_front();
    if (ch !== exp_c.ch)
      report($sformatf("out_char 0x%02h, expected 0x%02h", ch, exp_c.ch));
    if (last !== exp_c.last)
      report($sformatf("last_char %0b, expected %0b (char 0x%02h)", last, exp_c.last, exp_c.ch));
  endtask

  function automatic int unsigned outstanding();
    return expected_chars.size();
  endfunction
endclass

module base64_stream_encoder_tb;
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte = '0;
  logic       eom_flag = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [6:0] out_char;
  logic       last_char;

  encoded_char_board board = new();
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;

  base64_stream_encoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .data_byte_i     (data_byte),
    .end_of_message_i(eom_flag),
    .empty           (empty),
    .pop             (pop),
    .out_char_o      (out_char),
    .last_char_o     (last_char)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: pop pattern follows a randomly redrawn stall mode
  initial begin
    int mode;
    int unsigned cyc;
    mode = 0;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      if (cyc % 48 == 0) mode = $urandom_range(0, 3);
      @(negedge clk_i);
      case (mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= ((cyc / 3) % 2 == 0);
      endcase
      cyc++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) board.check_char(out_char, last_char);
  end

  task automatic hold_off(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eom);
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) burst_left = 60;
      else burst_left = $urandom_range(1, 16);
      hold_off($urandom_range(0, 6));
    end
    burst_left--;
    @(negedge clk_i);
    push <= 1'b1;
    data_byte <= b;
    eom_flag <= eom;
    do @(posedge clk_i); while (full);
    board.note_byte(b, eom);
    bytes_sent++;
  endtask

  // sender pauses until every predicted character has been popped
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  logic [7:0] dir_bytes [24] = '{
    8'h00,
    8'hFF,
    8'hFF, 8'h00,
    8'h00, 8'hFF,
    8'h00, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF,
    8'hFB, 8'hEF, 8'hBE,
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
    8'hF0, 8'h0F, 8'hC0, 8'h3F
  };
  int unsigned dir_lens [10] = '{1, 1, 2, 2, 3, 3, 3, 5, 4, 0};

  initial begin
    int unsigned idx;
    int unsigned msg_len;
    bit drained_mid;
    idx = 0;
    drained_mid = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single byte, two-byte and three-byte finals, alphabet ends, group then short final
    for (int m = 0; m < 9; m++) begin
      for (int k = 0; k < dir_lens[m]; k++) begin
        push_byte(dir_bytes[idx], k == dir_lens[m] - 1);
        idx++;
      end
    end
    drain();

    while (bytes_sent < 524) begin
      if ($urandom_range(0, 9) == 0) msg_len = $urandom_range(10, 40);
      else msg_len = $urandom_range(1, 9);
      for (int k = 0; k < msg_len; k++) push_byte(pick_byte(), k == msg_len - 1);
      if (!drained_mid && bytes_sent > 270) begin
        drain();
        drained_mid = 1;
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (board.outstanding() != 0)
      board.report($sformatf("%0d characters never arrived", board.outstanding()));
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
